// ===== src/bloom_filter_double_hash_unit_assert.svh =====
// Assertion macros for the Bloom filter unit.
// Needs a clk and an active-low rst_n in the including module.
`ifndef BLOOM_FILTER_DOUBLE_HASH_UNIT_ASSERT_SVH
`define BLOOM_FILTER_DOUBLE_HASH_UNIT_ASSERT_SVH

// same-cycle implication
`define BFDH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BFDH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/bfdh_pkg.sv =====
// Shared constants and types of the Bloom filter unit.
// No dependencies.
`timescale 1ns / 1ps

package bfdh_pkg;

  localparam int TABLE_BITS = 1024;
  localparam int NUM_PROBES = 3;
  localparam int WORD_COUNT = (TABLE_BITS + 63) / 64;
  localparam int WORD_W     = $clog2(WORD_COUNT);
  localparam int POS_W      = $clog2(TABLE_BITS);
  localparam int SIZE_W     = $clog2(TABLE_BITS + 1);
  localparam int CFG_W      = 11;
  localparam int PROBE_W    = (NUM_PROBES > 1) ? $clog2(NUM_PROBES) : 1;

  localparam logic [63:0] FNV_OFFSET = 64'hcbf29ce484222325;
  localparam logic [63:0] FNV_LOW    = 64'h1b3;
  localparam logic [63:0] MIX_MUL_A  = 64'd3935559000370003845;
  localparam logic [63:0] MIX_ADD_A  = 64'd2691343689449507681;
  localparam logic [63:0] MIX_MUL_B  = 64'd4768777513237032717;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_CHECK = 1'b1;

  typedef struct packed {
    logic        done;
    logic [63:0] h1;
    logic [63:0] h2;
  } hash_res_t;

  typedef struct packed {
    logic             done;
    logic [POS_W-1:0] rem;
  } mod_res_t;

endpackage

// ===== src/bloom_filter_double_hash_unit.sv =====
// Bloom filter unit: one key at a time, add or check, over a 16-word bit memory.
// Flow: hash the key, then for each of the three probes a bit-serial remainder by the size
// in use and a one-word read-modify-write, then load the output register.
// A new key waits until the last result is in the output register; out_ready low can stall it.
// Reset (rst_n low, synchronous) and any size write clear table and count; size resets to 1024.
// Depends on bfdh_pkg, bfdh_hash, bfdh_mod and the assertion macro header.
`timescale 1ns / 1ps
`include "bloom_filter_double_hash_unit_assert.svh"

module bloom_filter_double_hash_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_op,
  input  logic [63:0]                  in_key,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_present,
  output logic [bfdh_pkg::SIZE_W-1:0]  out_bits_set,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [bfdh_pkg::CFG_W-1:0]   cfg_filter_bits
);
  import bfdh_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_HASH   = 4'b0010,
    S_MOD    = 4'b0100,
    S_UPDATE = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  logic                done_pend_r, done_pend_nxt;
  logic                op_r, op_nxt;
  logic                all_set_r, all_set_nxt;
  logic [PROBE_W-1:0]  probe_r, probe_nxt;
  logic [63:0]         pos_r, pos_nxt;
  logic [63:0]         h2_r, h2_nxt;
  logic [WORD_W-1:0]   word_idx_r, word_idx_nxt;
  logic [5:0]          bit_idx_r, bit_idx_nxt;
  logic [WORD_COUNT-1:0] valid_r, valid_nxt;
  logic [SIZE_W-1:0]   count_r, count_nxt;
  logic [CFG_W-1:0]    filter_bits_r, filter_bits_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_present_r, out_present_nxt;
  logic [SIZE_W-1:0]   out_bits_r, out_bits_nxt;

  logic [63:0]         mem [WORD_COUNT];
  logic [63:0]         rd_r;
  logic                mem_we;
  logic [63:0]         mem_wdata;
  logic                rd_en;
  logic [63:0]         word_cur;
  logic                hit;
  logic [SIZE_W-1:0]   size_use;
  logic                accept;
  logic                cfg_wr;
  logic                hash_start;
  logic                mod_start;
  logic [63:0]         mod_value;
  hash_res_t           hash_res;
  mod_res_t            mod_res;

  assign accept    = in_valid && in_ready;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign in_ready  = (state_r == S_IDLE) && !done_pend_r;
  assign cfg_ready = (state_r == S_IDLE) && !done_pend_r;
  assign hash_start = accept;

  always_comb begin
    if (filter_bits_r == '0) begin
      size_use = SIZE_W'(1);
    end else if (32'(filter_bits_r) > TABLE_BITS) begin
      size_use = SIZE_W'(TABLE_BITS);
    end else begin
      size_use = SIZE_W'(filter_bits_r);
    end
  end

  assign word_cur = valid_r[word_idx_r] ? rd_r : 64'd0;
  assign hit      = word_cur[bit_idx_r];
  assign rd_en    = (state_r == S_MOD) && mod_res.done;

  always_comb begin
    state_nxt       = state_r;
    done_pend_nxt   = done_pend_r;
    op_nxt          = op_r;
    all_set_nxt     = all_set_r;
    probe_nxt       = probe_r;
    pos_nxt         = pos_r;
    h2_nxt          = h2_r;
    word_idx_nxt    = word_idx_r;
    bit_idx_nxt     = bit_idx_r;
    valid_nxt       = valid_r;
    count_nxt       = count_r;
    filter_bits_nxt = filter_bits_r;
    out_present_nxt = out_present_r;
    out_bits_nxt    = out_bits_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    mem_we          = 1'b0;
    mem_wdata       = word_cur | (64'd1 << bit_idx_r);
    mod_start       = 1'b0;
    mod_value       = hash_res.h1;

    if (cfg_wr) begin
      filter_bits_nxt = cfg_filter_bits;
      valid_nxt       = '0;
      count_nxt       = '0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt      = in_op;
          all_set_nxt = 1'b1;
          probe_nxt   = '0;
          state_nxt   = S_HASH;
        end
      end
      S_HASH: begin
        if (hash_res.done) begin
          pos_nxt   = hash_res.h1;
          h2_nxt    = hash_res.h2;
          mod_start = 1'b1;
          mod_value = hash_res.h1;
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        if (mod_res.done) begin
          word_idx_nxt = mod_res.rem[POS_W-1:6];
          bit_idx_nxt  = mod_res.rem[5:0];
          state_nxt    = S_UPDATE;
        end
      end
      S_UPDATE: begin
        if (op_r == OP_CHECK) begin
          all_set_nxt = all_set_r && hit;
        end else if (!hit) begin
          mem_we                = 1'b1;
          valid_nxt[word_idx_r] = 1'b1;
          count_nxt             = count_r + SIZE_W'(1);
        end
        if (probe_r == PROBE_W'(NUM_PROBES - 1)) begin
          done_pend_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          probe_nxt = probe_r + PROBE_W'(1);
          pos_nxt   = pos_r + h2_r;
          mod_start = 1'b1;
          mod_value = pos_r + h2_r;
          state_nxt = S_MOD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // hold the finished result until the output register is free
    if (done_pend_r && (!out_valid_r || out_ready)) begin
      done_pend_nxt   = 1'b0;
      out_valid_nxt   = 1'b1;
      out_present_nxt = (op_r == OP_CHECK) && all_set_r;
      out_bits_nxt    = count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[word_idx_r] <= mem_wdata;
    end
    if (rd_en) begin
      rd_r <= mem[mod_res.rem[POS_W-1:6]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      done_pend_r   <= 1'b0;
      valid_r       <= '0;
      count_r       <= '0;
      filter_bits_r <= CFG_W'(1024);
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      done_pend_r   <= done_pend_nxt;
      valid_r       <= valid_nxt;
      count_r       <= count_nxt;
      filter_bits_r <= filter_bits_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    op_r          <= op_nxt;
    all_set_r     <= all_set_nxt;
    probe_r       <= probe_nxt;
    pos_r         <= pos_nxt;
    h2_r          <= h2_nxt;
    word_idx_r    <= word_idx_nxt;
    bit_idx_r     <= bit_idx_nxt;
    out_present_r <= out_present_nxt;
    out_bits_r    <= out_bits_nxt;
  end

  bfdh_hash u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (hash_start),
    .key   (in_key),
    .res   (hash_res)
  );

  bfdh_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (mod_value),
    .divisor  (size_use),
    .res      (mod_res)
  );

  assign out_valid    = out_valid_r;
  assign out_present  = out_present_r;
  assign out_bits_set = out_bits_r;

  `BFDH_ASSERT_NEXT(a_accept_busy, accept, !in_ready, "input taken while busy")
  `BFDH_ASSERT_NOW(a_count_bound, 1'b1, count_r <= size_use, "count above size in use")
  `BFDH_ASSERT_NEXT(a_cfg_clears, cfg_wr, (count_r == '0) && (valid_r == '0),
                    "size write did not clear table")
  `BFDH_ASSERT_NOW(a_write_on_add, mem_we, (state_r == S_UPDATE) && (op_r == OP_ADD),
                   "table written outside an add")

endmodule

// ===== src/bfdh_hash.sv =====
// Sequential FNV-1 and multiply-xorshift hashing of one 64-bit key.
// Depends on bfdh_pkg.
`timescale 1ns / 1ps

module bfdh_hash (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [63:0]       key,
  output bfdh_pkg::hash_res_t res
);
  import bfdh_pkg::*;

  typedef enum logic [4:0] {
    H_IDLE = 5'b00001,
    H_FNV  = 5'b00010,
    H_MUL  = 5'b00100,
    H_MIXA = 5'b01000,
    H_MIXB = 5'b10000
  } hstate_t;

  hstate_t     state_r, state_nxt;
  logic [2:0]  fcnt_r, fcnt_nxt;
  logic [1:0]  mcnt_r, mcnt_nxt;
  logic        second_r, second_nxt;
  logic        done_r, done_nxt;
  logic [63:0] key_r, key_nxt;
  logic [63:0] h1_r, h1_nxt;
  logic [63:0] h2_r, h2_nxt;
  logic [63:0] ma_r, ma_nxt;
  logic [63:0] mb_r, mb_nxt;
  logic [63:0] prod_r, prod_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [63:0] va, vb;

  always_comb begin
    state_nxt  = state_r;
    fcnt_nxt   = fcnt_r;
    mcnt_nxt   = mcnt_r;
    second_nxt = second_r;
    done_nxt   = 1'b0;
    key_nxt    = key_r;
    h1_nxt     = h1_r;
    h2_nxt     = h2_r;
    ma_nxt     = ma_r;
    mb_nxt     = mb_r;
    prod_nxt   = prod_r;
    acc_nxt    = acc_r;
    va         = acc_r + MIX_ADD_A;
    va         = va ^ (va >> 21);
    va         = va ^ (va << 37);
    va         = va ^ (va >> 4);
    vb         = acc_r;
    vb         = vb ^ (vb << 20);
    vb         = vb ^ (vb >> 41);
    vb         = vb ^ (vb << 5);
    case (state_r)
      H_IDLE: begin
        if (start) begin
          key_nxt   = key;
          h1_nxt    = FNV_OFFSET;
          ma_nxt    = key;
          mb_nxt    = MIX_MUL_A;
          fcnt_nxt  = '0;
          state_nxt = H_FNV;
        end
      end
      H_FNV: begin
        h1_nxt   = ((h1_r << 40) + (h1_r * FNV_LOW)) ^ {56'd0, key_r[7:0]};
        key_nxt  = key_r >> 8;
        fcnt_nxt = fcnt_r + 3'd1;
        if (fcnt_r == 3'd7) begin
          mcnt_nxt   = '0;
          second_nxt = 1'b0;
          state_nxt  = H_MUL;
        end
      end
      H_MUL: begin
        mcnt_nxt = mcnt_r + 2'd1;
        case (mcnt_r)
          2'd0: begin
            prod_nxt = {32'd0, ma_r[31:0]} * {32'd0, mb_r[31:0]};
          end
          2'd1: begin
            acc_nxt  = prod_r;
            prod_nxt = {32'd0, ma_r[63:32]} * {32'd0, mb_r[31:0]};
          end
          2'd2: begin
            acc_nxt  = acc_r + {prod_r[31:0], 32'd0};
            prod_nxt = {32'd0, ma_r[31:0]} * {32'd0, mb_r[63:32]};
          end
          default: begin
            acc_nxt   = acc_r + {prod_r[31:0], 32'd0};
            state_nxt = second_r ? H_MIXB : H_MIXA;
          end
        endcase
      end
      H_MIXA: begin
        ma_nxt     = va;
        mb_nxt     = MIX_MUL_B;
        mcnt_nxt   = '0;
        second_nxt = 1'b1;
        state_nxt  = H_MUL;
      end
      H_MIXB: begin
        h2_nxt    = vb;
        done_nxt  = 1'b1;
        state_nxt = H_IDLE;
      end
      default: begin
        state_nxt = H_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= H_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    fcnt_r   <= fcnt_nxt;
    mcnt_r   <= mcnt_nxt;
    second_r <= second_nxt;
    key_r    <= key_nxt;
    h1_r     <= h1_nxt;
    h2_r     <= h2_nxt;
    ma_r     <= ma_nxt;
    mb_r     <= mb_nxt;
    prod_r   <= prod_nxt;
    acc_r    <= acc_nxt;
  end

  assign res.done = done_r;
  assign res.h1   = h1_r;
  assign res.h2   = h2_r;

endmodule

// ===== src/bfdh_mod.sv =====
// Bit-serial remainder of a 64-bit value by the filter size in use, one bit a cycle.
// Depends on bfdh_pkg.
`timescale 1ns / 1ps

module bfdh_mod (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [63:0]               dividend,
  input  logic [bfdh_pkg::SIZE_W-1:0] divisor,
  output bfdh_pkg::mod_res_t        res
);
  import bfdh_pkg::*;

  localparam int TW = POS_W + 1;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [5:0]        cnt_r, cnt_nxt;
  logic [63:0]       dvd_r, dvd_nxt;
  logic [SIZE_W-1:0] dvs_r, dvs_nxt;
  logic [POS_W-1:0]  rem_r, rem_nxt;
  logic [TW-1:0]     trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    trial    = {rem_r, dvd_r[63]};
    if (trial >= TW'(dvs_r)) begin
      trial = trial - TW'(dvs_r);
    end
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = dividend;
      dvs_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = trial[POS_W-1:0];
      dvd_nxt = dvd_r << 1;
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
  end

  assign res.done = done_r;
  assign res.rem  = rem_r;

endmodule

// ===== dv/tb_bloom_filter_double_hash_unit.sv =====
// Self-checking testbench for bloom_filter_double_hash_unit: add and check keys under
// several filter sizes and handshake pacing, compared against an in-bench filter model.
// Depends on bfdh_pkg and the unit under test.
`timescale 1ns / 1ps

module tb_bloom_filter_double_hash_unit;
  import bfdh_pkg::*;

  localparam logic [63:0] FNV_STEP_MUL = 64'h0000_0100_0000_01b3;
  localparam int          STALL_LIMIT = 5000;
  localparam int          TAIL_CYCLES = 300;

  typedef struct {
    logic        op;
    logic [63:0] key;
  } key_request_t;

  typedef struct {
    logic              present;
    logic [SIZE_W-1:0] bits_set;
  } lookup_answer_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              in_op = OP_ADD;
  logic [63:0]       in_key = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_present;
  logic [SIZE_W-1:0] out_bits_set;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_W-1:0]  cfg_filter_bits = '0;

  key_request_t   key_backlog[$];
  lookup_answer_t pending_answers[$];
  logic [63:0]    added_keys[$];

  logic [TABLE_BITS-1:0] bloom_map = '0;
  logic [SIZE_W-1:0]     fill_count = '0;
  logic [CFG_W-1:0]      size_reg = 11'd1024;

  logic in_taken = 1'b0;
  int   send_gap_pct = 0;
  int   sink_stall_pct = 0;
  int   mismatches = 0;
  int   quiet_cycles = 0;

  bloom_filter_double_hash_unit DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_key          (in_key),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_present     (out_present),
    .out_bits_set    (out_bits_set),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_filter_bits (cfg_filter_bits)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic [63:0] fnv1_fold(input logic [63:0] key);
    logic [63:0] h;
    h = FNV_OFFSET;
    for (int n = 0; n < 8; n++) begin
      h = h * FNV_STEP_MUL;
      h = h ^ {56'd0, key[8*n +: 8]};
    end
    return h;
  endfunction

  function automatic logic [63:0] mix_scramble(input logic [63:0] key);
    logic [63:0] v;
    v = key * MIX_MUL_A + MIX_ADD_A;
    v = v ^ (v >> 21);
    v = v ^ (v << 37);
    v = v ^ (v >> 4);
    v = v * MIX_MUL_B;
    v = v ^ (v << 20);
    v = v ^ (v >> 41);
    v = v ^ (v << 5);
    return v;
  endfunction

  task automatic predict_lookup(input logic op, input logic [63:0] key,
                                output lookup_answer_t ans);
    logic [63:0] h1;
    logic [63:0] h2;
    logic [63:0] span;
    logic [63:0] pos;
    logic        hit;
    h1 = fnv1_fold(key);
    h2 = mix_scramble(key);
    if (size_reg == 0) span = 64'd1;
    else if (size_reg > TABLE_BITS) span = 64'(TABLE_BITS);
    else span = 64'(size_reg);
    hit = 1'b1;
    for (int j = 0; j < NUM_PROBES; j++) begin
      pos = (h1 + 64'(j) * h2) % span;
      if (op == OP_CHECK) begin
        if (!bloom_map[pos]) hit = 1'b0;
      end else if (!bloom_map[pos]) begin
        bloom_map[pos] = 1'b1;
        fill_count = fill_count + 1'b1;
      end
    end
    ans.present  = (op == OP_CHECK) && hit;
    ans.bits_set = fill_count;
  endtask

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("%0t ns: mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // predictor, scoreboard and watchdog
  always @(posedge clk) begin
    lookup_answer_t ans;
    lookup_answer_t want;
    logic moved;
    if (rst_n) begin
      moved = 1'b0;
      if (cfg_valid && cfg_ready) begin
        size_reg   = cfg_filter_bits;
        bloom_map  = '0;
        fill_count = '0;
        moved      = 1'b1;
      end
      if (in_valid && in_ready) begin
        predict_lookup(in_op, in_key, ans);
        pending_answers.push_back(ans);
        moved = 1'b1;
      end
      in_taken <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        moved = 1'b1;
        if (pending_answers.size() == 0) begin
          flag_mismatch("result with nothing pending", out_bits_set, 0);
        end else begin
          want = pending_answers.pop_front();
          if (out_present !== want.present)
            flag_mismatch("present", out_present, want.present);
          if (out_bits_set !== want.bits_set)
            flag_mismatch("bits_set", out_bits_set, want.bits_set);
        end
      end
      if (moved || !(in_valid || cfg_valid || key_backlog.size() != 0 ||
                     pending_answers.size() != 0)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("tb_bloom_filter_double_hash_unit: errors");
          $finish;
        end
      end
    end
  end

  // input driver and output back-pressure
  always @(negedge clk) begin
    key_request_t nxt;
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        if (key_backlog.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          nxt = key_backlog.pop_front();
          in_op    <= nxt.op;
          in_key   <= nxt.key;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  function automatic void queue_item(input logic op, input logic [63:0] key);
    key_request_t r;
    r.op  = op;
    r.key = key;
    key_backlog.push_back(r);
  endfunction

  function automatic logic [63:0] rand_key();
    case ($urandom_range(7))
      0:       return 64'($urandom_range(255));
      1:       return {$urandom, 32'hffff_ffff};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic drain_all();
    while (key_backlog.size() != 0 || in_valid || pending_answers.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_size(input logic [CFG_W-1:0] v);
    @(negedge clk);
    cfg_filter_bits <= v;
    cfg_valid       <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_pace(input int mode);
    case (mode)
      0: begin send_gap_pct = 0;  sink_stall_pct = 0;  end
      1: begin send_gap_pct = 55; sink_stall_pct = 0;  end
      2: begin send_gap_pct = 0;  sink_stall_pct = 55; end
      default: begin send_gap_pct = 38; sink_stall_pct = 38; end
    endcase
  endtask

  initial begin
    logic [CFG_W-1:0] size_plan[12];
    logic [CFG_W-1:0] span_cfg;
    logic [63:0]      k;
    int               roll;
    size_plan = '{11'd1, 11'd2, 11'd7, 11'd64, 11'd1024, 11'd1023,
                  11'd100, 11'd1025, 11'd2047, 11'd0, 11'd13, 11'd500};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset size, repeated keys, extreme keys
    queue_item(OP_ADD,   64'd0);
    queue_item(OP_CHECK, 64'd0);
    queue_item(OP_ADD,   64'hffff_ffff_ffff_ffff);
    queue_item(OP_CHECK, 64'hffff_ffff_ffff_ffff);
    queue_item(OP_CHECK, 64'd1);
    queue_item(OP_ADD,   64'd0);
    queue_item(OP_CHECK, 64'h8000_0000_0000_0000);
    queue_item(OP_ADD,   64'h0123_4567_89ab_cdef);
    queue_item(OP_CHECK, 64'h0123_4567_89ab_cdef);
    queue_item(OP_ADD,   64'haaaa_aaaa_aaaa_aaaa);
    queue_item(OP_CHECK, 64'h5555_5555_5555_5555);
    queue_item(OP_ADD,   64'h0000_0000_0000_00ff);
    queue_item(OP_CHECK, 64'hff00_0000_0000_0000);
    drain_all();
    // zero size acts as one bit
    write_size(11'd0);
    queue_item(OP_CHECK, 64'd42);
    queue_item(OP_ADD,   64'd42);
    queue_item(OP_CHECK, 64'hdead_beef_0000_0001);
    drain_all();
    // oversize clamps to the full table
    write_size(11'd2047);
    queue_item(OP_ADD,   64'hffff_ffff_ffff_ffff);
    queue_item(OP_CHECK, 64'hffff_ffff_ffff_ffff);
    queue_item(OP_CHECK, 64'd0);
    drain_all();

    for (int p = 0; p < 12; p++) begin
      span_cfg = (p == 10) ? CFG_W'($urandom_range(2047)) : size_plan[p];
      write_size(span_cfg);
      set_pace(p % 4);
      added_keys.delete();
      for (int i = 0; i < 52; i++) begin
        roll = $urandom_range(99);
        if (roll < 45 || added_keys.size() == 0) begin
          k = rand_key();
          added_keys.push_back(k);
          queue_item(OP_ADD, k);
        end else if (roll < 75) begin
          queue_item(OP_CHECK, added_keys[$urandom_range(added_keys.size() - 1)]);
        end else if (roll < 92) begin
          queue_item(OP_CHECK, rand_key());
        end else begin
          queue_item(OP_ADD, added_keys[$urandom_range(added_keys.size() - 1)]);
        end
      end
      drain_all();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("tb_bloom_filter_double_hash_unit: clean");
    else
      $display("tb_bloom_filter_double_hash_unit: errors");
    $finish;
  end

endmodule
